>>> hdl/gdda_pkg.sv
// Shared types, constants and calendar functions for the Gregorian date day-arithmetic block.
// Depends on nothing; imported by every other file of the block.
package gdda_pkg;

    // Latest year that counts as valid.
    localparam int MAX_YEAR = 9999;

    // Field widths of the stream items.
    localparam int YEAR_IN_W = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int OFF_W     = 21;
    localparam int COUNT_W   = 22;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // Internal year register width: wide enough for the input field and for MAX_YEAR.
    localparam int YR_W = ($clog2(MAX_YEAR + 1) > YEAR_IN_W) ? $clog2(MAX_YEAR + 1) : YEAR_IN_W;

    // Day numbers count days since 0001-01-01.
    localparam int DN_1900 = 365 * 1899 + 1899 / 4 - 1899 / 100 + 1899 / 400;
    localparam int DN_LAST = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;
    localparam int DN_W    = $clog2(DN_LAST + 1);

    // Width of the shared adder, signed two's complement.
    localparam int SUM_W = ((DN_W > OFF_W) ? DN_W : OFF_W) + 2;

    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    // Request to and response from the shared add/subtract unit.
    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] res;
        logic             neg;
    } alu_rsp_t;

    // Years in one calendar chunk: 400, 100, 4 and 1 years.
    function automatic logic [SUM_W-1:0] chunk_years(input logic [1:0] lvl);
        logic [SUM_W-1:0] v;
        case (lvl)
            2'd0:    v = SUM_W'(400);
            2'd1:    v = SUM_W'(100);
            2'd2:    v = SUM_W'(4);
            default: v = SUM_W'(1);
        endcase
        return v;
    endfunction

    // Days in the same chunks.
    function automatic logic [SUM_W-1:0] chunk_days(input logic [1:0] lvl);
        logic [SUM_W-1:0] v;
        case (lvl)
            2'd0:    v = SUM_W'(146097);
            2'd1:    v = SUM_W'(36524);
            2'd2:    v = SUM_W'(1461);
            default: v = SUM_W'(365);
        endcase
        return v;
    endfunction

    // Length of a month; zero for a month code outside 1 to 12.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                    input logic leap);
        logic [DAY_W-1:0] v;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
            4'd2:                                        v = leap ? 5'd29 : 5'd28;
            default:                                     v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/gregorian_date_day_arithmetic_top.sv
// Top level of the Gregorian date day-arithmetic block: stream ports, sequencer, result register.
// Depends on gdda_pkg and gdda_alu.
//
// Each transaction carries two dates, a signed day offset and an operation code in tuser.
// Operation 0 adds the offset to date A and returns the new date, saturating to 0001-01-01 or
// to the last day of the final valid year and raising range_error; operation 1 returns the
// absolute day count between A and B. An invalid date (bad year, month or day) is taken as
// 1900-01-01. The block works on one transaction at a time: each date conversion walks through
// 400-, 100-, 4- and 1-year chunks and then months, one step at a time through the single
// shared adder, with a test state and an accumulate state per chunk. s_axis_tready is high
// only while the sequencer is idle; a finished result sits in the output register, so a new
// transaction can be taken while the previous result still waits for m_axis_tready.
module gregorian_date_day_arithmetic_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
    // day_b[45:41], offset_days[66:46], zero fill [71:67]
    input  logic [gdda_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // res_year[13:0], res_month[17:14], res_day[22:18], day_count[44:23],
    // range_error[45], zero fill [47:46]
    output logic [gdda_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import gdda_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LOAD  = 14'b00000000000010,  // range check, p = year - 1
        S_DTEST = 14'b00000000000100,  // try to take a chunk of years off p
        S_DACC  = 14'b00000000001000,  // add the chunk's days to the day number
        S_DMON  = 14'b00000000010000,  // day check and whole months
        S_DDAY  = 14'b00000000100000,  // add day of month
        S_DDONE = 14'b00000001000000,
        S_DIFF  = 14'b00000010000000,
        S_DIFF2 = 14'b00000100000000,
        S_ADD   = 14'b00001000000000,
        S_FTEST = 14'b00010000000000,  // try to take a chunk of days off the day number
        S_FACC  = 14'b00100000000000,  // add the chunk's years to the year
        S_FMON  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    // Chunk counts that decide whether the year under work is a leap year.
    typedef struct packed {
        logic hund3;   // three 100-year chunks taken
        logic four24;  // twenty-four 4-year chunks taken
        logic one3;    // three 1-year chunks taken
    } leap_flags_t;

    state_t                 state_reg, state_next;
    logic                   sel_b_reg, sel_b_next;
    logic [1:0]             lvl_reg, lvl_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [MONTH_W-1:0]     mo_reg, mo_next;
    leap_flags_t            flg_reg, flg_next;
    logic                   m_valid_reg, m_valid_next;

    logic [SUM_W-1:0]       dn_reg, dn_next;
    logic [YR_W-1:0]        yr_reg, yr_next;
    logic [DN_W-1:0]        na_reg, na_next;
    logic [YEAR_IN_W-1:0]   rs_year_reg, rs_year_next;
    logic [MONTH_W-1:0]     rs_month_reg, rs_month_next;
    logic [DAY_W-1:0]       rs_day_reg, rs_day_next;
    logic [COUNT_W-1:0]     rs_count_reg, rs_count_next;
    logic                   rs_err_reg, rs_err_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    // Accepted transaction.
    logic                   func_reg;
    logic [YEAR_IN_W-1:0]   ya_reg, yb_reg;
    logic [MONTH_W-1:0]     ma_reg, mb_reg;
    logic [DAY_W-1:0]       da_reg, db_reg;
    logic [OFF_W-1:0]       off_reg;

    logic                   in_fire;
    logic [YEAR_IN_W-1:0]   cy;
    logic [MONTH_W-1:0]     cm;
    logic [DAY_W-1:0]       cd;
    logic [DAY_W-1:0]       cd_m1;
    logic                   leap;
    logic                   cap;
    logic [DAY_W-1:0]       mdays;
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    gdda_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Date under conversion: A first, then B for a difference.
    assign cy    = sel_b_reg ? yb_reg : ya_reg;
    assign cm    = sel_b_reg ? mb_reg : ma_reg;
    assign cd    = sel_b_reg ? db_reg : da_reg;
    assign cd_m1 = cd - 5'd1;

    // Year y = p + 1 with p = 400a + 100b + 4c + e: leap when e == 3 and (c != 24 or b == 3).
    assign leap  = flg_reg.one3 && (!flg_reg.four24 || flg_reg.hund3);
    // Month length of the date being decoded (S_FMON) or of the running month (S_DMON).
    assign mdays = month_days(mo_reg, leap);
    // The 100- and 1-year levels never take a fourth chunk on the way back to a date.
    assign cap   = ((lvl_reg == 2'd1) || (lvl_reg == 2'd3)) && (cnt_reg == 5'd3);

    // Capture the chunk counts of the level that has just ended.
    function automatic leap_flags_t level_end(input leap_flags_t f, input logic [1:0] lvl,
                                              input logic [4:0] cnt);
        leap_flags_t r;
        r = f;
        case (lvl)
            2'd1:    r.hund3  = (cnt == 5'd3);
            2'd2:    r.four24 = (cnt == 5'd24);
            2'd3:    r.one3   = (cnt == 5'd3);
            default: r = f;
        endcase
        return r;
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        sel_b_next    = sel_b_reg;
        lvl_next      = lvl_reg;
        cnt_next      = cnt_reg;
        mo_next       = mo_reg;
        flg_next      = flg_reg;
        dn_next       = dn_reg;
        yr_next       = yr_reg;
        na_next       = na_reg;
        rs_year_next  = rs_year_reg;
        rs_month_next = rs_month_reg;
        rs_day_next   = rs_day_reg;
        rs_count_next = rs_count_reg;
        rs_err_next   = rs_err_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        alu_req.a     = dn_reg;
        alu_req.b     = '0;
        alu_req.sub   = 1'b0;

        // Drop the result once the downstream side has taken it.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sel_b_next    = 1'b0;
                    rs_year_next  = '0;
                    rs_month_next = '0;
                    rs_day_next   = '0;
                    rs_count_next = '0;
                    rs_err_next   = 1'b0;
                    state_next    = S_LOAD;
                end
            end

            S_LOAD:
            begin
                alu_req.a   = SUM_W'(cy);
                alu_req.b   = SUM_W'(1);
                alu_req.sub = 1'b1;
                if ((cy == '0) || (YR_W'(cy) > YR_W'(MAX_YEAR)) ||
                    (cm < 4'd1) || (cm > 4'd12))
                begin
                    dn_next    = SUM_W'(DN_1900);
                    state_next = S_DDONE;
                end
                else
                begin
                    yr_next    = alu_rsp.res[YR_W-1:0];
                    dn_next    = '0;
                    lvl_next   = 2'd0;
                    cnt_next   = '0;
                    state_next = S_DTEST;
                end
            end

            S_DTEST:
            begin
                alu_req.a   = SUM_W'(yr_reg);
                alu_req.b   = chunk_years(lvl_reg);
                alu_req.sub = 1'b1;
                if (!alu_rsp.neg)
                begin
                    yr_next    = alu_rsp.res[YR_W-1:0];
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = S_DACC;
                end
                else
                begin
                    flg_next = level_end(flg_reg, lvl_reg, cnt_reg);
                    cnt_next = '0;
                    if (lvl_reg == 2'd3)
                    begin
                        mo_next    = 4'd1;
                        state_next = S_DMON;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + 2'd1;
                    end
                end
            end

            S_DACC:
            begin
                alu_req.a  = dn_reg;
                alu_req.b  = chunk_days(lvl_reg);
                dn_next    = alu_rsp.res;
                state_next = S_DTEST;
            end

            S_DMON:
            begin
                alu_req.a = dn_reg;
                alu_req.b = SUM_W'(mdays);
                if ((cd == '0) || (cd > month_days(cm, leap)))
                begin
                    dn_next    = SUM_W'(DN_1900);
                    state_next = S_DDONE;
                end
                else if (mo_reg < cm)
                begin
                    dn_next = alu_rsp.res;
                    mo_next = mo_reg + 4'd1;
                end
                else
                begin
                    state_next = S_DDAY;
                end
            end

            S_DDAY:
            begin
                alu_req.a  = dn_reg;
                alu_req.b  = SUM_W'(cd_m1);
                dn_next    = alu_rsp.res;
                state_next = S_DDONE;
            end

            S_DDONE:
            begin
                if (!sel_b_reg)
                begin
                    na_next = dn_reg[DN_W-1:0];
                    if (func_reg)
                    begin
                        sel_b_next = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end

            S_DIFF:
            begin
                alu_req.a   = SUM_W'(na_reg);
                alu_req.b   = dn_reg;
                alu_req.sub = 1'b1;
                if (alu_rsp.neg)
                begin
                    state_next = S_DIFF2;
                end
                else
                begin
                    rs_count_next = (alu_rsp.res > SUM_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                                      : alu_rsp.res[COUNT_W-1:0];
                    state_next    = S_OUT;
                end
            end

            S_DIFF2:
            begin
                alu_req.a     = dn_reg;
                alu_req.b     = SUM_W'(na_reg);
                alu_req.sub   = 1'b1;
                rs_count_next = (alu_rsp.res > SUM_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                                  : alu_rsp.res[COUNT_W-1:0];
                state_next    = S_OUT;
            end

            S_ADD:
            begin
                alu_req.a = SUM_W'(na_reg);
                alu_req.b = {{(SUM_W - OFF_W){off_reg[OFF_W-1]}}, off_reg};
                if (alu_rsp.neg)
                begin
                    dn_next     = '0;
                    rs_err_next = 1'b1;
                end
                else if (alu_rsp.res > SUM_W'(DN_LAST))
                begin
                    dn_next     = SUM_W'(DN_LAST);
                    rs_err_next = 1'b1;
                end
                else
                begin
                    dn_next = alu_rsp.res;
                end
                yr_next    = YR_W'(1);
                lvl_next   = 2'd0;
                cnt_next   = '0;
                state_next = S_FTEST;
            end

            S_FTEST:
            begin
                alu_req.a   = dn_reg;
                alu_req.b   = chunk_days(lvl_reg);
                alu_req.sub = 1'b1;
                if (!alu_rsp.neg && !cap)
                begin
                    dn_next    = alu_rsp.res;
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = S_FACC;
                end
                else
                begin
                    flg_next = level_end(flg_reg, lvl_reg, cnt_reg);
                    cnt_next = '0;
                    if (lvl_reg == 2'd3)
                    begin
                        mo_next    = 4'd1;
                        state_next = S_FMON;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + 2'd1;
                    end
                end
            end

            S_FACC:
            begin
                alu_req.a  = SUM_W'(yr_reg);
                alu_req.b  = chunk_years(lvl_reg);
                yr_next    = alu_rsp.res[YR_W-1:0];
                state_next = S_FTEST;
            end

            S_FMON:
            begin
                alu_req.a   = dn_reg;
                alu_req.b   = SUM_W'(mdays);
                alu_req.sub = 1'b1;
                if ((mo_reg < 4'd12) && !alu_rsp.neg)
                begin
                    dn_next = alu_rsp.res;
                    mo_next = mo_reg + 4'd1;
                end
                else
                begin
                    rs_year_next  = yr_reg[YEAR_IN_W-1:0];
                    rs_month_next = mo_reg;
                    rs_day_next   = dn_reg[DAY_W-1:0] + 5'd1;
                    state_next    = S_OUT;
                end
            end

            S_OUT:
            begin
                // Hold here until the output register is free.
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = {2'b00, rs_err_reg, rs_count_reg, rs_day_reg,
                                    rs_month_reg, rs_year_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_b_reg   <= 1'b0;
            lvl_reg     <= 2'd0;
            cnt_reg     <= '0;
            mo_reg      <= 4'd1;
            flg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_b_reg   <= sel_b_next;
            lvl_reg     <= lvl_next;
            cnt_reg     <= cnt_next;
            mo_reg      <= mo_next;
            flg_reg     <= flg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and result registers: no reset needed.
    always_ff @(posedge clk)
    begin
        dn_reg       <= dn_next;
        yr_reg       <= yr_next;
        na_reg       <= na_next;
        rs_year_reg  <= rs_year_next;
        rs_month_reg <= rs_month_next;
        rs_day_reg   <= rs_day_next;
        rs_count_reg <= rs_count_next;
        rs_err_reg   <= rs_err_next;
        m_data_reg   <= m_data_next;
    end

    // Capture the transaction on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= s_axis_tuser;
            ya_reg   <= s_axis_tdata[13:0];
            ma_reg   <= s_axis_tdata[17:14];
            da_reg   <= s_axis_tdata[22:18];
            yb_reg   <= s_axis_tdata[36:23];
            mb_reg   <= s_axis_tdata[40:37];
            db_reg   <= s_axis_tdata[45:41];
            off_reg  <= s_axis_tdata[66:46];
        end
    end

endmodule

>>> hdl/gdda_alu.sv
// Shared add/subtract unit of the date block, with a sign flag on the result.
// Depends on gdda_pkg.
module gdda_alu (
    input  gdda_pkg::alu_req_t req,
    output gdda_pkg::alu_rsp_t rsp
);
    import gdda_pkg::*;

    logic [SUM_W-1:0] sum;

    assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
    assign rsp.res = sum;
    assign rsp.neg = sum[SUM_W-1];

endmodule

>>> hdl/gdda_checker.sv
// Port-level assertions for the Gregorian date day-arithmetic block, bound to its top level.
// Depends on gdda_pkg and gregorian_date_day_arithmetic_top.
module gdda_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [gdda_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import gdda_pkg::*;

    logic [13:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [21:0] o_count;
    logic        o_err;

    assign o_year  = m_axis_tdata[13:0];
    assign o_month = m_axis_tdata[17:14];
    assign o_day   = m_axis_tdata[22:18];
    assign o_count = m_axis_tdata[44:23];
    assign o_err   = m_axis_tdata[45];

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The sequencer is busy after taking a transaction.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    // A result is either a plain day count or a well-formed date.
    a_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((o_year == 14'd0) && (o_month == 4'd0) && (o_day == 5'd0) && !o_err) ||
            ((o_count == 22'd0) && (o_month >= 4'd1) && (o_month <= 4'd12) &&
             (o_day >= 5'd1) && (o_year >= 14'd1)))
        else $error("malformed result");

    // A range error always comes with a saturated date.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_err |->
            ((o_year == 14'd1) && (o_month == 4'd1) && (o_day == 5'd1)) ||
            ((o_year == 14'(MAX_YEAR)) && (o_month == 4'd12) && (o_day == 5'd31)))
        else $error("range error without saturated date");

endmodule

bind gregorian_date_day_arithmetic_top gdda_checker u_gdda_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for gregorian_date_day_arithmetic_top: date add and day difference.
// Depends on gdda_pkg and the block's RTL; a built-in calendar predictor checks every result.
// Directed corner dates come first, then random batches with stalls on both stream sides.
module tb_top;

    // Operation carried in s_axis_tuser.
    typedef enum bit {
        OP_ADD_DAYS = 1'b0,
        OP_DAY_DIFF = 1'b1
    } date_op_e;

    // One input transaction, fields at the block's widths.
    typedef struct packed {
        date_op_e    func;
        logic [13:0] year_a;
        logic [3:0]  month_a;
        logic [4:0]  day_a;
        logic [13:0] year_b;
        logic [3:0]  month_b;
        logic [4:0]  day_b;
        logic [20:0] offset;
    } date_req_t;

    // One output transaction.
    typedef struct packed {
        logic [13:0] res_year;
        logic [3:0]  res_month;
        logic [4:0]  res_day;
        logic [21:0] day_count;
        logic        range_error;
    } date_res_t;

    // Days in 400-, 100-, 4- and 1-year spans of the Gregorian calendar.
    localparam longint DAYS_400Y = 146097;
    localparam longint DAYS_100Y = 36524;
    localparam longint DAYS_4Y   = 1461;
    localparam longint DAYS_1Y   = 365;

    localparam longint LAST_YEAR = longint'(gdda_pkg::MAX_YEAR);

    // Run shape: receiver hold-off, no-idle window and drain time.
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 1500;
    localparam int QUIET_FROM    = 100;
    localparam int QUIET_TO      = 130;
    localparam int IDLE_PERCENT  = 8;
    localparam int DRAIN_CYCLES  = 600;
    localparam int RANDOM_BATCH  = 58;
    localparam longint RUN_LIMIT = 10_000_000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [gdda_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [gdda_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

    date_req_t dates_to_send [$];
    date_res_t expected_dates [$];
    date_req_t offered_req;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  fail_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic quiet_window;

    gregorian_date_day_arithmetic_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock, period 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Neither side idles while this window of accepted transactions is open.
    assign quiet_window = (items_accepted >= QUIET_FROM) && (items_accepted < QUIET_TO);

    // ---------------------------------------------------------------------------------------
    // Calendar predictor
    // ---------------------------------------------------------------------------------------

    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of month m in year y; zero for a month outside 1 to 12.
    function automatic longint month_length(input longint y, input longint m);
        longint len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // Days elapsed since 0001-01-01 for a valid date.
    function automatic longint days_since_epoch(input longint y, input longint m, input longint d);
        longint p;
        longint n;
        longint k;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (k = 1; k < m; k++)
            n += month_length(y, k);
        return n + d - 1;
    endfunction

    // Day number of an input date; any invalid date counts as 1900-01-01.
    function automatic longint resolve_day_number(input longint y, input longint m,
                                                  input longint d);
        if (y == 0 || y > LAST_YEAR || m < 1 || m > 12 || d == 0 || d > month_length(y, m))
            return days_since_epoch(1900, 1, 1);
        return days_since_epoch(y, m, d);
    endfunction

    function automatic date_res_t predict_date_result(input date_req_t r);
        date_res_t e;
        longint    na;
        longint    nb;
        longint    n;
        longint    last_day;
        longint    yr;
        longint    span;
        longint    mo;
        longint    diff;
        e  = '0;
        na = resolve_day_number(longint'(r.year_a), longint'(r.month_a), longint'(r.day_a));
        nb = resolve_day_number(longint'(r.year_b), longint'(r.month_b), longint'(r.day_b));
        if (r.func == OP_ADD_DAYS)
        begin
            last_day = days_since_epoch(LAST_YEAR, 12, 31);
            n = na + longint'($signed(r.offset));
            // Saturate at either end of the calendar and flag it.
            if (n < 0)
            begin
                n = 0;
                e.range_error = 1'b1;
            end
            else if (n > last_day)
            begin
                n = last_day;
                e.range_error = 1'b1;
            end
            // Peel off 400-, 100-, 4- and 1-year spans, then whole months.
            yr = 1 + 400 * (n / DAYS_400Y);
            n  = n % DAYS_400Y;
            span = n / DAYS_100Y;
            if (span > 3)
                span = 3;
            n  -= span * DAYS_100Y;
            yr += 100 * span;
            span = n / DAYS_4Y;
            n  -= span * DAYS_4Y;
            yr += 4 * span;
            span = n / DAYS_1Y;
            if (span > 3)
                span = 3;
            n  -= span * DAYS_1Y;
            yr += span;
            mo = 1;
            while (mo < 12 && n >= month_length(yr, mo))
            begin
                n -= month_length(yr, mo);
                mo++;
            end
            e.res_year  = 14'(yr);
            e.res_month = 4'(mo);
            e.res_day   = 5'(n + 1);
        end
        else
        begin
            diff = (na > nb) ? na - nb : nb - na;
            if (diff > longint'(gdda_pkg::COUNT_MAX))
                diff = longint'(gdda_pkg::COUNT_MAX);
            e.day_count = 22'(diff);
        end
        return e;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------------

    task automatic push_request(input date_op_e op, input int ya, input int ma, input int da,
                                input int yb, input int mb, input int db, input int off);
        date_req_t r;
        r.func    = op;
        r.year_a  = 14'(ya);
        r.month_a = 4'(ma);
        r.day_a   = 5'(da);
        r.year_b  = 14'(yb);
        r.month_b = 4'(mb);
        r.day_b   = 5'(db);
        r.offset  = 21'(off);
        dates_to_send.push_back(r);
        items_queued++;
    endtask

    // Valid date, weighted towards both ends of the year range.
    task automatic random_valid_date(output logic [13:0] y, output logic [3:0] m,
                                     output logic [4:0] d);
        int pick;
        int yy;
        int mm;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            yy = $urandom_range(1, 3);
        else if (pick == 1)
            yy = $urandom_range(gdda_pkg::MAX_YEAR - 2, gdda_pkg::MAX_YEAR);
        else
            yy = $urandom_range(1, gdda_pkg::MAX_YEAR);
        mm = $urandom_range(1, 12);
        y = 14'(yy);
        m = 4'(mm);
        d = 5'($urandom_range(1, 32'(month_length(longint'(yy), longint'(mm)))));
    endtask

    task automatic push_random_request();
        date_req_t r;
        int        pick;
        int        off;
        r.func = ($urandom_range(0, 1) != 0) ? OP_DAY_DIFF : OP_ADD_DAYS;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            // Noise: raw field values, mostly invalid dates.
            r.year_a  = 14'($urandom);
            r.month_a = 4'($urandom);
            r.day_a   = 5'($urandom);
            r.year_b  = 14'($urandom);
            r.month_b = 4'($urandom);
            r.day_b   = 5'($urandom);
        end
        else
        begin
            random_valid_date(r.year_a, r.month_a, r.day_a);
            random_valid_date(r.year_b, r.month_b, r.day_b);
        end
        // Offsets: mostly short hops, some spanning decades, some full range.
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            off = $urandom_range(0, 800);
            off = off - 400;
        end
        else if (pick < 8)
        begin
            off = $urandom_range(0, 80000);
            off = off - 40000;
        end
        else
            off = int'($urandom);
        r.offset = 21'(off);
        dates_to_send.push_back(r);
        items_queued++;
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
                 results_seen, what, want, got);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------------------------
    // Driver: offer queued transactions, hold each until accepted, predict on acceptance.
    // ---------------------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_dates.push_back(predict_date_result(offered_req));
                items_accepted <= items_accepted + 1;
            end
            // Only move on once the current transaction has gone; never drop a valid early.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (dates_to_send.size() != 0 &&
                    (quiet_window || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    offered_req    = dates_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered_req.func;
                    s_axis_tdata  <= {5'b0, offered_req.offset, offered_req.day_b,
                                      offered_req.month_b, offered_req.year_b,
                                      offered_req.day_a, offered_req.month_a,
                                      offered_req.year_a};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off so the block fills and stalls.
    // ---------------------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AT)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet_window || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ---------------------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction, field by field.
    // ---------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        date_res_t want;
        date_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.res_year    = m_axis_tdata[13:0];
            got.res_month   = m_axis_tdata[17:14];
            got.res_day     = m_axis_tdata[22:18];
            got.day_count   = m_axis_tdata[44:23];
            got.range_error = m_axis_tdata[45];
            if (expected_dates.size() == 0)
                report_mismatch("result with nothing pending", 0, 1);
            else
            begin
                want = expected_dates.pop_front();
                if (got.res_year != want.res_year)
                    report_mismatch("res_year", longint'(want.res_year),
                                    longint'(got.res_year));
                if (got.res_month != want.res_month)
                    report_mismatch("res_month", longint'(want.res_month),
                                    longint'(got.res_month));
                if (got.res_day != want.res_day)
                    report_mismatch("res_day", longint'(want.res_day),
                                    longint'(got.res_day));
                if (got.day_count != want.day_count)
                    report_mismatch("day_count", longint'(want.day_count),
                                    longint'(got.day_count));
                if (got.range_error != want.range_error)
                    report_mismatch("range_error", longint'(want.range_error),
                                    longint'(got.range_error));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Sequence: reset, directed corners, two random batches with a full drain between them.
    // ---------------------------------------------------------------------------------------
    initial
    begin
        // Calendar edges, leap rules and saturation.
        push_request(OP_ADD_DAYS, 2000, 2, 29, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 1999, 12, 31, 1, 1, 1, 1);
        push_request(OP_ADD_DAYS, 2100, 2, 28, 1, 1, 1, 1);
        push_request(OP_ADD_DAYS, 1600, 2, 28, 1, 1, 1, 1);
        push_request(OP_ADD_DAYS, 1, 1, 1, 1, 1, 1, -1);
        push_request(OP_ADD_DAYS, gdda_pkg::MAX_YEAR, 12, 31, 1, 1, 1, 1);
        push_request(OP_ADD_DAYS, gdda_pkg::MAX_YEAR, 1, 1, 1, 1, 1, 1048575);
        push_request(OP_ADD_DAYS, 1, 1, 1, 1, 1, 1, -1048576);
        push_request(OP_ADD_DAYS, gdda_pkg::MAX_YEAR, 12, 31, 1, 1, 1, -1048576);
        push_request(OP_ADD_DAYS, 1, 1, 1, 1, 1, 1, 1048575);
        // Invalid dates fall back to 1900-01-01.
        push_request(OP_ADD_DAYS, 2023, 0, 15, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 2023, 13, 1, 1, 1, 1, 10);
        push_request(OP_ADD_DAYS, 16383, 15, 31, 16383, 15, 31, -1);
        push_request(OP_ADD_DAYS, 0, 1, 1, 1, 1, 1, 5);
        push_request(OP_ADD_DAYS, gdda_pkg::MAX_YEAR + 1, 1, 1, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 2023, 4, 31, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 1900, 2, 29, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 2004, 2, 29, 1, 1, 1, 0);
        push_request(OP_ADD_DAYS, 2023, 6, 0, 1, 1, 1, 0);
        // Differences: widest span both ways, equal dates, invalid operands.
        push_request(OP_DAY_DIFF, 1, 1, 1, gdda_pkg::MAX_YEAR, 12, 31, 0);
        push_request(OP_DAY_DIFF, gdda_pkg::MAX_YEAR, 12, 31, 1, 1, 1, -1);
        push_request(OP_DAY_DIFF, 2024, 3, 1, 2024, 3, 1, 0);
        push_request(OP_DAY_DIFF, 2000, 2, 30, 16383, 15, 31, 0);
        push_request(OP_DAY_DIFF, 2023, 7, 4, 0, 0, 0, 1048575);
        for (int i = 0; i < RANDOM_BATCH; i++)
            push_random_request();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Pause the sender until every outstanding result has come back.
        while (dates_to_send.size() != 0 || s_axis_tvalid || expected_dates.size() != 0 ||
               results_seen < items_queued)
            @(posedge clk);
        for (int i = 0; i < RANDOM_BATCH; i++)
            push_random_request();

        // Drain, then allow for stray results before the verdict.
        while (dates_to_send.size() != 0 || s_axis_tvalid || expected_dates.size() != 0 ||
               results_seen < items_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_dates.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> gregorian_date_day_arithmetic_top.f
hdl/gdda_pkg.sv
hdl/gdda_alu.sv
hdl/gregorian_date_day_arithmetic_top.sv
hdl/gdda_checker.sv
sim/tb_top.sv
